// File: hdl/pgf_pkg.sv
// ----------------------------------------------------------------------------
// pgf_pkg
// Shared types, constants and address helpers for the Potts grain flip block.
// ----------------------------------------------------------------------------
package pgf_pkg;

   localparam int GRID_SIZE   = 64;
   localparam int SPIN_BITS   = 16;
   localparam int COORD_BITS  = $clog2(GRID_SIZE);
   localparam int ADDR_BITS   = 2 * COORD_BITS;
   localparam int FIELD_COORD = 6;
   localparam int FIELD_SPIN  = 16;
   localparam int PICK_BITS   = 3;
   localparam int NB_COUNT    = 8;
   localparam int FETCH_BITS  = 4;
   localparam int COUNT_BITS  = 4;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_FLIP  = 2'd2,
      REQ_SPARE = 2'd3
   } req_kind_type;

   // Offsets are coded as two-bit two's complement: -1, 0 or +1.
   localparam logic [1:0] NB_DR [NB_COUNT] = '{2'b11, 2'b11, 2'b11, 2'b00,
                                               2'b00, 2'b01, 2'b01, 2'b01};
   localparam logic [1:0] NB_DC [NB_COUNT] = '{2'b11, 2'b00, 2'b01, 2'b11,
                                               2'b01, 2'b11, 2'b00, 2'b01};

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [SPIN_BITS-1:0]  spin_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      spin_type wr_data;
   } ram_cmd_type;

   typedef struct packed {
      logic     valid;
      spin_type spin;
      logic     flipped;
      logic     interior;
   } result_type;

   function automatic coord_type wrap_step(coord_type base, logic [1:0] delta);
      return coord_type'(base + {{(COORD_BITS-2){delta[1]}}, delta});
   endfunction

   function automatic addr_type cell_addr(coord_type row, coord_type col);
      return {row, col};
   endfunction

endpackage

// File: hdl/pgf_req_if.sv
// ----------------------------------------------------------------------------
// pgf_req_if
// Request channel: load, read or flip items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pgf_req_if import pgf_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             req_type;
   logic [FIELD_COORD-1:0] site_row;
   logic [FIELD_COORD-1:0] site_col;
   logic [FIELD_SPIN-1:0]  spin_value;
   logic [PICK_BITS-1:0]   neighbour_pick;

   modport source (output valid, req_type, site_row, site_col, spin_value,
                   neighbour_pick, input ready);
   modport sink   (input valid, req_type, site_row, site_col, spin_value,
                   neighbour_pick, output ready);
endinterface

// File: hdl/pgf_rsp_if.sv
// ----------------------------------------------------------------------------
// pgf_rsp_if
// Response channel: one result item per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pgf_rsp_if import pgf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_SPIN-1:0] spin_out;
   logic                  flipped;
   logic                  interior;

   modport source (output valid, spin_out, flipped, interior, input ready);
   modport sink   (input valid, spin_out, flipped, interior, output ready);
endinterface

// File: hdl/pgf_spin_ram.sv
// ----------------------------------------------------------------------------
// pgf_spin_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pgf_spin_ram #(
   parameter int DATA_BITS = 16,
   parameter int ADDR_BITS = 12
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/pgf_flip_ctrl.sv
// ----------------------------------------------------------------------------
// pgf_flip_ctrl
// Sequencer that stores loads, reads sites back, and for a flip fetches a site
// and its neighbours, evaluates the flip rule and writes a flipped site back.
// ----------------------------------------------------------------------------
module pgf_flip_ctrl import pgf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pgf_req_if.sink     req_bus,
   output ram_cmd_type ram_cmd,
   input  spin_type    ram_rdata,
   output result_type  result,
   input  logic        result_ready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DRAIN,
      ST_EVAL,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic                is_flip_ff, is_flip_in;
   coord_type           row_ff, row_in;
   coord_type           col_ff, col_in;
   logic [PICK_BITS-1:0] pick_ff, pick_in;
   logic [FETCH_BITS-1:0] cnt_ff, cnt_in;
   logic                cap_valid_ff, cap_valid_in;
   logic [FETCH_BITS-1:0] cap_idx_ff, cap_idx_in;
   spin_type            own_ff, own_in;
   spin_type            nb_ff [NB_COUNT];
   spin_type            nb_in [NB_COUNT];
   spin_type            cand_ff, cand_in;
   logic [COUNT_BITS-1:0] same_own_ff, same_own_in;
   logic                interior_ff, interior_in;
   spin_type            res_spin_ff, res_spin_in;
   logic                res_flipped_ff, res_flipped_in;
   logic                res_interior_ff, res_interior_in;

   logic [FETCH_BITS-1:0] fetch_last;
   logic [FETCH_BITS-1:0] nb_sel;
   addr_type            site_addr;
   addr_type            fetch_addr;
   logic [NB_COUNT-1:0] own_match;
   logic [NB_COUNT-1:0] cand_match;
   logic [COUNT_BITS-1:0] same_cand;
   logic                do_flip;

   function automatic logic [PICK_BITS-1:0] nb_sel_of(logic [FETCH_BITS-1:0] idx);
      logic [FETCH_BITS-1:0] k;
      k = FETCH_BITS'(idx - 1'b1);
      return k[PICK_BITS-1:0];
   endfunction

   assign site_addr  = cell_addr(row_ff, col_ff);
   assign fetch_last = is_flip_ff ? FETCH_BITS'(NB_COUNT) : '0;
   assign nb_sel     = FETCH_BITS'(cnt_ff - 1'b1);
   assign fetch_addr = (cnt_ff == '0) ? site_addr :
                       cell_addr(wrap_step(row_ff, NB_DR[nb_sel[PICK_BITS-1:0]]),
                                 wrap_step(col_ff, NB_DC[nb_sel[PICK_BITS-1:0]]));

   always_comb begin
      for (int k = 0; k < NB_COUNT; k++) begin
         own_match[k]  = (nb_ff[k] == own_ff);
         cand_match[k] = (nb_ff[k] == cand_ff);
      end
   end

   assign same_cand = COUNT_BITS'($countones(cand_match));
   assign do_flip   = !interior_ff && (cand_ff != own_ff) && (same_cand >= same_own_ff);

   always_comb begin
      state_in        = state_ff;
      is_flip_in      = is_flip_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      pick_in         = pick_ff;
      cnt_in          = cnt_ff;
      cap_valid_in    = 1'b0;
      cap_idx_in      = cap_idx_ff;
      own_in          = own_ff;
      nb_in           = nb_ff;
      cand_in         = cand_ff;
      same_own_in     = same_own_ff;
      interior_in     = interior_ff;
      res_spin_in     = res_spin_ff;
      res_flipped_in  = res_flipped_ff;
      res_interior_in = res_interior_ff;
      ram_cmd.rd_en   = 1'b0;
      ram_cmd.rd_addr = fetch_addr;
      ram_cmd.wr_en   = 1'b0;
      ram_cmd.wr_addr = site_addr;
      ram_cmd.wr_data = cand_ff;

      if (cap_valid_ff) begin
         if (cap_idx_ff == '0) begin
            own_in = ram_rdata;
         end else begin
            nb_in[nb_sel_of(cap_idx_ff)] = ram_rdata;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid && !reset) begin
               row_in     = req_bus.site_row[COORD_BITS-1:0];
               col_in     = req_bus.site_col[COORD_BITS-1:0];
               pick_in    = req_bus.neighbour_pick;
               is_flip_in = (req_bus.req_type == REQ_FLIP);
               cnt_in     = '0;
               if (req_bus.req_type == REQ_LOAD) begin
                  ram_cmd.wr_en   = 1'b1;
                  ram_cmd.wr_addr = cell_addr(req_bus.site_row[COORD_BITS-1:0],
                                              req_bus.site_col[COORD_BITS-1:0]);
                  ram_cmd.wr_data = req_bus.spin_value[SPIN_BITS-1:0];
                  res_spin_in     = req_bus.spin_value[SPIN_BITS-1:0];
                  res_flipped_in  = 1'b0;
                  res_interior_in = 1'b0;
                  state_in        = ST_FINISH;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            ram_cmd.rd_en = 1'b1;
            cap_valid_in  = 1'b1;
            cap_idx_in    = cnt_ff;
            if (cnt_ff == fetch_last) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = FETCH_BITS'(cnt_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            if (is_flip_ff) begin
               state_in = ST_EVAL;
            end else begin
               res_spin_in     = ram_rdata;
               res_flipped_in  = 1'b0;
               res_interior_in = 1'b0;
               state_in        = ST_FINISH;
            end
         end
         ST_EVAL: begin
            same_own_in = COUNT_BITS'($countones(own_match));
            interior_in = (own_match == '1);
            cand_in     = nb_ff[pick_ff];
            state_in    = ST_DECIDE;
         end
         ST_DECIDE: begin
            ram_cmd.wr_en   = do_flip;
            res_spin_in     = do_flip ? cand_ff : own_ff;
            res_flipped_in  = do_flip;
            res_interior_in = interior_ff;
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            if (result_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_valid_ff <= cap_valid_in;
      end
      is_flip_ff      <= is_flip_in;
      row_ff          <= row_in;
      col_ff          <= col_in;
      pick_ff         <= pick_in;
      cnt_ff          <= cnt_in;
      cap_idx_ff      <= cap_idx_in;
      own_ff          <= own_in;
      nb_ff           <= nb_in;
      cand_ff         <= cand_in;
      same_own_ff     <= same_own_in;
      interior_ff     <= interior_in;
      res_spin_ff     <= res_spin_in;
      res_flipped_ff  <= res_flipped_in;
      res_interior_ff <= res_interior_in;
   end

   assign req_bus.ready   = (state_ff == ST_IDLE) && !reset;
   assign result.valid    = (state_ff == ST_FINISH);
   assign result.spin     = res_spin_ff;
   assign result.flipped  = res_flipped_ff;
   assign result.interior = res_interior_ff;

endmodule

// File: hdl/potts_grain_flip.sv
// ----------------------------------------------------------------------------
// potts_grain_flip
// Zero-temperature Potts grain-growth site update on a periodic square lattice.
// ----------------------------------------------------------------------------
// The lattice of grain spins lives in one synchronous RAM with a single read
// port, and every item is handled in turn: the controller takes the next item
// only once the last one has been handed over to the output register. A load
// writes the site and goes straight to the hand-over; a read makes one read of
// the site and a drain step for its data. A flip attempt makes nine reads, one
// a cycle, of the site and its eight neighbours through the one read port, then
// a drain step for the last read data, a counting step, a decision step that
// writes the site back when it flips, and the hand-over. A new item is accepted
// while the previous result still waits in the output register.
module potts_grain_flip import pgf_pkg::*; (
   input logic     clock,
   input logic     reset,
   pgf_req_if.sink req_bus,
   pgf_rsp_if.source rsp_bus
);

   ram_cmd_type ram_cmd;
   spin_type    ram_rdata;
   result_type  result;
   logic        result_ready;

   logic        rsp_valid_ff, rsp_valid_in;
   spin_type    rsp_spin_ff, rsp_spin_in;
   logic        rsp_flipped_ff, rsp_flipped_in;
   logic        rsp_interior_ff, rsp_interior_in;

   pgf_spin_ram #(
      .DATA_BITS (SPIN_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (ram_rdata)
   );

   pgf_flip_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .ram_cmd      (ram_cmd),
      .ram_rdata    (ram_rdata),
      .result       (result),
      .result_ready (result_ready)
   );

   assign result_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_spin_in     = rsp_spin_ff;
      rsp_flipped_in  = rsp_flipped_ff;
      rsp_interior_in = rsp_interior_ff;
      if (result.valid && result_ready) begin
         rsp_valid_in    = 1'b1;
         rsp_spin_in     = result.spin;
         rsp_flipped_in  = result.flipped;
         rsp_interior_in = result.interior;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_spin_ff     <= rsp_spin_in;
      rsp_flipped_ff  <= rsp_flipped_in;
      rsp_interior_ff <= rsp_interior_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.spin_out = FIELD_SPIN'(rsp_spin_ff);
   assign rsp_bus.flipped  = rsp_flipped_ff;
   assign rsp_bus.interior = rsp_interior_ff;

endmodule

// File: tb/potts_grain_flip_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// potts_grain_flip_test
// Self-checking bench for the Potts grain flip block. Loads small patches of
// grain spins, fires reads and flip attempts into them with random stalls on
// both channels, and checks every result item against a lattice kept here.
// ----------------------------------------------------------------------------
module potts_grain_flip_test;
   import pgf_pkg::*;

   localparam int CELLS      = GRID_SIZE * GRID_SIZE;
   localparam int ITEM_COUNT = 1650;

   typedef logic [PICK_BITS-1:0] pick_type;

   typedef struct packed {
      spin_type spin;
      logic     flipped;
      logic     interior;
   } site_outcome_type;

   class grain_ledger;
      spin_type         lattice [CELLS];
      site_outcome_type outcome_q [$];
      int               errors = 0;

      function void note_request(req_kind_type kind, coord_type row, coord_type col,
                                 spin_type value, pick_type pick);
         addr_type         site;
         spin_type         ring [NB_COUNT];
         spin_type         own;
         int               same_own;
         int               same_cand;
         int               k;
         site_outcome_type outcome;
         site = {row, col};
         outcome = '0;
         if (kind == REQ_LOAD) begin
            lattice[site] = value;
         end else if (kind == REQ_FLIP) begin
            own = lattice[site];
            same_own = 0;
            same_cand = 0;
            k = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) begin
                     ring[k] = lattice[{coord_type'(row + dr), coord_type'(col + dc)}];
                     if (ring[k] == own) same_own++;
                     k++;
                  end
               end
            end
            if (same_own == NB_COUNT) begin
               outcome.interior = 1'b1;
            end else if (ring[pick] != own) begin
               foreach (ring[j]) if (ring[j] == ring[pick]) same_cand++;
               if (same_cand >= same_own) begin
                  lattice[site] = ring[pick];
                  outcome.flipped = 1'b1;
               end
            end
         end
         outcome.spin = lattice[site];
         outcome_q = {outcome_q, outcome};
      endfunction

      function void compare_field(string label, logic [SPIN_BITS-1:0] want,
                                  logic [SPIN_BITS-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            errors++;
         end
      endfunction

      function void check_result(spin_type spin, logic flipped, logic interior);
         site_outcome_type want;
         if (outcome_q.size() == 0) begin
            $display("%0t: unexpected result item, actual spin %h flipped %b interior %b",
                     $time, spin, flipped, interior);
            errors++;
         end else begin
            want = outcome_q.pop_front();
            compare_field("spin_out", want.spin, spin);
            compare_field("flipped", SPIN_BITS'(want.flipped), SPIN_BITS'(flipped));
            compare_field("interior", SPIN_BITS'(want.interior), SPIN_BITS'(interior));
         end
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   bit          steady;
   bit          loaded [CELLS];
   int          sent_items;
   grain_ledger ledger = new;

   pgf_req_if req_bus ();
   pgf_rsp_if rsp_bus ();

   potts_grain_flip u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic send_item(req_kind_type kind, coord_type row, coord_type col,
                            spin_type value, pick_type pick);
      while (!steady && $urandom_range(0, 99) < 12) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.req_type       <= kind;
      req_bus.site_row       <= row;
      req_bus.site_col       <= col;
      req_bus.spin_value     <= value;
      req_bus.neighbour_pick <= pick;
      do @(posedge clock); while (!req_bus.ready);
      ledger.note_request(kind, row, col, value, pick);
      if (kind == REQ_LOAD) loaded[{row, col}] = 1'b1;
      sent_items++;
      steady = sent_items >= 700 && sent_items < 1000;
   endtask

   task automatic load_site(coord_type row, coord_type col, spin_type value);
      send_item(REQ_LOAD, row, col, value, pick_type'($urandom_range(0, 7)));
   endtask

   function automatic bit region_loaded(coord_type row, coord_type col);
      bit all_in = 1'b1;
      for (int dr = -1; dr <= 1; dr++)
         for (int dc = -1; dc <= 1; dc++)
            all_in &= loaded[{coord_type'(row + dr), coord_type'(col + dc)}];
      return all_in;
   endfunction

   function automatic coord_type random_coord();
      coord_type edges [4] = '{6'd0, 6'd1, 6'd62, 6'd63};
      if ($urandom_range(0, 99) < 30) return edges[$urandom_range(0, 3)];
      return coord_type'($urandom_range(0, GRID_SIZE - 1));
   endfunction

   task automatic directed_items();
      for (int dr = -1; dr <= 1; dr++)
         for (int dc = -1; dc <= 1; dc++)
            load_site(coord_type'(dr), coord_type'(dc), 16'hFFFF);
      send_item(REQ_READ, 6'd0, 6'd0, 16'hAAAA, 3'd5);
      send_item(REQ_SPARE, 6'd63, 6'd63, 16'h0000, 3'd7);
      send_item(REQ_FLIP, 6'd0, 6'd0, 16'h5555, 3'd3);
      load_site(6'd0, 6'd0, 16'h0000);
      send_item(REQ_FLIP, 6'd0, 6'd0, 16'h0000, 3'd7);
      load_site(6'd63, 6'd1, 16'h0000);
      send_item(REQ_FLIP, 6'd0, 6'd0, 16'hFFFF, 3'd2);
      send_item(REQ_FLIP, 6'd0, 6'd0, 16'h0000, 3'd4);
      load_site(6'd63, 6'd63, 16'h0000);
      load_site(6'd63, 6'd0, 16'h0000);
      load_site(6'd0, 6'd63, 16'h0000);
      send_item(REQ_FLIP, 6'd0, 6'd0, 16'hAAAA, 3'd0);
      load_site(6'd1, 6'd63, 16'h5555);
      send_item(REQ_READ, 6'd1, 6'd1, 16'h5555, 3'd6);
      send_item(REQ_FLIP, 6'd0, 6'd0, 16'hFFFF, 3'd1);
   endtask

   // A patch is a 5x5 block of a few grain ids; its inner 3x3 sites have every
   // neighbour loaded, so flips there are always legal.
   task automatic grow_patch();
      coord_type cr, cc, row, col;
      spin_type  palette [3];
      int        colours, bias, choice;
      cr = random_coord();
      cc = random_coord();
      palette[0] = spin_type'($urandom());
      palette[1] = $urandom_range(0, 4) == 0 ? ~palette[0] : spin_type'($urandom());
      palette[2] = spin_type'($urandom());
      colours = $urandom_range(1, 3);
      case ($urandom_range(0, 2))
         0: bias = 60;
         1: bias = 85;
         default: bias = 97;
      endcase
      for (int dr = -2; dr <= 2; dr++)
         for (int dc = -2; dc <= 2; dc++)
            load_site(coord_type'(cr + dr), coord_type'(cc + dc),
                      $urandom_range(0, 99) < bias ? palette[0]
                                                   : palette[$urandom_range(0, colours - 1)]);
      repeat ($urandom_range(15, 35)) begin
         choice = $urandom_range(0, 99);
         if (choice < 70) begin
            row = coord_type'(cr + $urandom_range(0, 2) - 1);
            col = coord_type'(cc + $urandom_range(0, 2) - 1);
            send_item(REQ_FLIP, row, col, spin_type'($urandom()),
                      pick_type'($urandom_range(0, 7)));
         end else if (choice < 80) begin
            row = coord_type'(cr + $urandom_range(0, 4) - 2);
            col = coord_type'(cc + $urandom_range(0, 4) - 2);
            send_item($urandom_range(0, 1) ? REQ_READ : REQ_SPARE, row, col,
                      spin_type'($urandom()), pick_type'($urandom_range(0, 7)));
         end else if (choice < 88) begin
            row = coord_type'(cr + $urandom_range(0, 4) - 2);
            col = coord_type'(cc + $urandom_range(0, 4) - 2);
            load_site(row, col, palette[$urandom_range(0, colours - 1)]);
         end else begin
            row = coord_type'($urandom_range(0, GRID_SIZE - 1));
            col = coord_type'($urandom_range(0, GRID_SIZE - 1));
            if (region_loaded(row, col) && $urandom_range(0, 1))
               send_item(REQ_FLIP, row, col, spin_type'($urandom()),
                         pick_type'($urandom_range(0, 7)));
            else if (loaded[{row, col}] && $urandom_range(0, 1))
               send_item(REQ_SPARE, row, col, spin_type'($urandom()),
                         pick_type'($urandom_range(0, 7)));
            else
               load_site(row, col, spin_type'($urandom()));
         end
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            ledger.check_result(rsp_bus.spin_out, rsp_bus.flipped, rsp_bus.interior);
         rsp_bus.ready <= !reset && (steady || $urandom_range(0, 99) >= 12);
      end
   end

   initial begin
      req_bus.valid          <= 1'b0;
      req_bus.req_type       <= REQ_LOAD;
      req_bus.site_row       <= '0;
      req_bus.site_col       <= '0;
      req_bus.spin_value     <= '0;
      req_bus.neighbour_pick <= '0;
      reset                  <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      directed_items();
      while (sent_items < ITEM_COUNT) grow_patch();
      req_bus.valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (ledger.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
